// ===== hw/rtl/rgbaob_pkg.sv =====
// Package for the RGBA8 over-blend block: payload types and blend constants.
// No dependencies; imported by the interfaces, the top level and the checker.
package rgbaob_pkg;

  localparam int unsigned OpacityW = 17;
  localparam int unsigned WnumW    = 24;
  localparam int unsigned NumW     = 32;

  // Q1.16 opacity of one, and the threshold for the fully opaque copy
  localparam logic [OpacityW-1:0] OpacityOne = 17'd65536;
  localparam logic [OpacityW-1:0] OpaqueThr  = 17'd65471;

  // blend denominator 255 * 65536
  localparam logic [WnumW-1:0] BlendDen = 24'd16711680;

  localparam logic [7:0] ByteMax = 8'hFF;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic [7:0] bg_alpha;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_last;
  } res_t;

endpackage

// ===== hw/rtl/rgbaob_pix_if.sv =====
// Valid/ready channel carrying one input pixel pair (foreground and background).
// Depends on rgbaob_pkg for the payload type.
interface rgbaob_pix_if;
  import rgbaob_pkg::*;

  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rgbaob_res_if.sv =====
// Valid/ready channel carrying one blended result pixel.
// Depends on rgbaob_pkg for the payload type.
interface rgbaob_res_if;
  import rgbaob_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rgbaob_div255.sv =====
// Two-stage floor division of a 16-bit value by 255 (reciprocal plus one correction).
// Stand-alone datapath; valid bits are tracked by the instantiating module.
module rgbaob_div255 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] q_i,
  output logic [8:0]  quot_o
);
  localparam logic [16:0] Base = 17'd255;

  logic [24:0] prod;
  logic [15:0] q_q;
  logic [8:0]  est_q;
  logic [16:0] t255;
  logic [16:0] rem;
  logic [8:0]  quot_d;
  logic [8:0]  quot_q;

  // estimate q*257/65536, never above the true quotient and at most one below
  assign prod = {1'b0, q_i, 8'b0} + {9'b0, q_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_i;
      est_q <= prod[24:16];
    end
  end

  assign t255   = {est_q, 8'b0} - {8'b0, est_q};
  assign rem    = {1'b0, q_q} - t255;
  assign quot_d = (rem >= Base) ? est_q + 9'd1 : est_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;
endmodule

// ===== hw/rtl/rgba_alpha_blend_over_top.sv =====
// RGBA8 "over" blend with global layer opacity, five register stages deep.
// Depends on rgbaob_pkg, rgbaob_pix_if, rgbaob_res_if and rgbaob_div255.
//
// Usage:
//   pix_i  - valid/ready channel, one foreground/background pixel pair per item.
//   res_o  - valid/ready channel, one blended pixel per item, in input order.
//   cfg_we_i / cfg_wdata_i - write the Q1.16 global opacity (values above
//            65536 act as 65536). Write only while no item is in flight.
//
// Throughput: one item per clock while res_o does not stall. An accepted item
// passes the stages weight, products, divide estimate, divide correction and
// output register in that order before it shows on res_o. Stages advance
// together on one enable; when res_o holds a result that is not taken, the
// whole pipe holds and pix_i.ready drops, so nothing is lost or repeated. An
// output register sits between the pipe and the receiver, and the pipe keeps
// filling into empty slots as long as the output is free or being taken.
//
// Reset clears all valid bits and sets the opacity to fully opaque; payload
// registers are not reset.
module rgba_alpha_blend_over_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rgbaob_pix_if.sink                      pix_i,
  rgbaob_res_if.source                    res_o,
  input  logic                            cfg_we_i,
  input  logic [rgbaob_pkg::OpacityW-1:0] cfg_wdata_i
);
  import rgbaob_pkg::*;

  // fields that ride along to the output stage
  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
    logic       last;
    logic       byp;
  } side_t;

  function automatic logic [NumW-1:0] mix_num(input logic [7:0] f, input logic [7:0] b,
                                              input logic [WnumW-1:0] w);
    logic [NumW-1:0] pf;
    logic [NumW-1:0] pb;
    pf = NumW'(f) * NumW'(w);
    pb = NumW'(b) * NumW'(BlendDen - w);
    return pf + pb;
  endfunction

  function automatic logic [7:0] sat8(input logic [9:0] v);
    return (v > 10'(ByteMax)) ? ByteMax : v[7:0];
  endfunction

  logic                en;
  logic [4:0]          vld_q;
  logic [OpacityW-1:0] opac_q;

  // opacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opac_q <= OpacityOne;
    end else if (cfg_we_i) begin
      opac_q <= cfg_wdata_i;
    end
  end

  // advance every stage when the output slot is empty or being taken
  assign en          = !vld_q[4] || res_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], pix_i.valid};
    end
  end

  // ---- stage 1: clamp opacity, weight numerator, alpha product ----
  logic [OpacityW-1:0] g_clamp;
  logic [WnumW-1:0]    wnum_full;
  logic [7:0]          inv_fa;
  logic                byp_d;
  logic [WnumW-1:0]    wnum_q;
  logic [15:0]         pa_q;
  logic [7:0]          bg_red_q, bg_green_q, bg_blue_q;
  side_t               side_q [1:4];

  // 255 * 65536 is the largest weight and still fits the weight width
  assign g_clamp   = (opac_q > OpacityOne) ? OpacityOne : opac_q;
  assign wnum_full = WnumW'(pix_i.data.fg_alpha) * WnumW'(g_clamp);
  assign inv_fa    = ByteMax - pix_i.data.fg_alpha;
  assign byp_d     = (g_clamp >= OpaqueThr) && (pix_i.data.fg_alpha == ByteMax);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wnum_q     <= wnum_full;
      pa_q       <= 16'(pix_i.data.bg_alpha) * 16'(inv_fa);
      bg_red_q   <= pix_i.data.bg_red;
      bg_green_q <= pix_i.data.bg_green;
      bg_blue_q  <= pix_i.data.bg_blue;
      side_q[1]  <= '{fg_red:   pix_i.data.fg_red,
                      fg_green: pix_i.data.fg_green,
                      fg_blue:  pix_i.data.fg_blue,
                      fg_alpha: pix_i.data.fg_alpha,
                      last:     pix_i.data.last_pixel,
                      byp:      byp_d};
    end
  end

  // ---- stage 2: full blend numerators; drop the low 16 bits (floor by 65536) ----
  logic [NumW-1:0] num_r, num_g, num_b;
  logic [15:0]     hi_q [0:3];

  assign num_r = mix_num(side_q[1].fg_red,   bg_red_q,   wnum_q);
  assign num_g = mix_num(side_q[1].fg_green, bg_green_q, wnum_q);
  assign num_b = mix_num(side_q[1].fg_blue,  bg_blue_q,  wnum_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hi_q[0]   <= num_r[NumW-1:16];
      hi_q[1]   <= num_g[NumW-1:16];
      hi_q[2]   <= num_b[NumW-1:16];
      hi_q[3]   <= pa_q;
      side_q[2] <= side_q[1];
    end
  end

  // ---- stages 3 and 4: divide by 255 ----
  logic [8:0] quot [0:3];

  for (genvar c = 0; c < 4; c++) begin : g_div
    rgbaob_div255 u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .q_i    (hi_q[c]),
      .quot_o (quot[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[3] <= side_q[2];
      side_q[4] <= side_q[3];
    end
  end

  // ---- stage 5: saturate, alpha add, opaque copy ----
  logic [9:0] alpha_sum;
  res_t       res_d;
  res_t       res_q;

  assign alpha_sum = {2'b0, side_q[4].fg_alpha} + {1'b0, quot[3]};

  always_comb begin
    if (side_q[4].byp) begin
      res_d.out_red   = side_q[4].fg_red;
      res_d.out_green = side_q[4].fg_green;
      res_d.out_blue  = side_q[4].fg_blue;
      res_d.out_alpha = side_q[4].fg_alpha;
    end else begin
      res_d.out_red   = sat8({1'b0, quot[0]});
      res_d.out_green = sat8({1'b0, quot[1]});
      res_d.out_blue  = sat8({1'b0, quot[2]});
      res_d.out_alpha = sat8(alpha_sum);
    end
    res_d.out_last = side_q[4].last;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = vld_q[4];
  assign res_o.data  = res_q;
endmodule

// ===== hw/rtl/rgbaob_chk.sv =====
// Port-level checker for the RGBA8 over-blend top level, attached by bind.
// Depends on rgbaob_pkg for the result type.
module rgbaob_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [7:0]        in_alpha_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input rgbaob_pkg::res_t  out_data_i
);
  import rgbaob_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // input side is open exactly when the output slot is free or being taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output state");

  // free-flowing pipe: result valid while the output keeps taking, flag carried, opaque alpha kept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_i && out_data_i.out_last == $past(in_last_i, 5) &&
        (($past(in_alpha_i, 5) != ByteMax) || out_data_i.out_alpha == ByteMax))
    else $error("result missing or wrong after fixed latency");

  // nothing shows right after reset
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid out of reset");
endmodule

bind rgba_alpha_blend_over_top rgbaob_chk u_rgbaob_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_alpha_i  (pix_i.data.fg_alpha),
  .in_last_i   (pix_i.data.last_pixel),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
